// ===== hdl/itd_pkg.sv =====
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants for the integer-to-decimal converter
// Holds the ASCII codes, the BCD correction constants, the sequencer state
// type, the conversion unit command type and the character hand-off struct.
// ----------------------------------------------------------------------------
`default_nettype none

package itd_pkg;

   // ASCII codes for the characters the block can produce.
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Shift-and-add-3 correction: a BCD digit of five or more gets three added
   // before the shift, so that it carries properly into the next digit.
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Commands to the shared conversion unit.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_SHIFT,
      CMD_POP
   } cmd_type;

   // One character handed from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] char_out;
      logic       last;
   } emit_type;

endpackage : itd_pkg

`default_nettype wire

// ===== hdl/itd_dabble.sv =====
// ----------------------------------------------------------------------------
// itd_dabble: shared binary-to-BCD shift unit
// Holds the magnitude being converted and the BCD digit register. One SHIFT
// command moves one binary bit into the BCD register with the add-3 fix-up;
// one POP command drops the most significant digit.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_dabble
   import itd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  wire logic                   clock,
   input  wire cmd_type                cmd,
   input  wire logic [VALUE_WIDTH-1:0] load_value,
   output logic      [3:0]             top_digit
);

   localparam int BCD_WIDTH = 4 * NUM_DIGITS;

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [VALUE_WIDTH-1:0] bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff;
   logic [BCD_WIDTH-1:0]   bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   // Add-3 correction on every digit; the digits are independent.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= BCD_ADJ_LIMIT) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + BCD_ADJ_ADD;
         end
      end
   end

   // Next value of the shift registers for each command.
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      unique case (cmd)
         CMD_HOLD: begin
            bin_in = bin_ff;
            bcd_in = bcd_ff;
         end
         CMD_LOAD: begin
            // The magnitude is taken unsigned, so the most negative value is exact.
            if (load_value[VALUE_WIDTH-1]) begin
               bin_in = (~load_value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
            end else begin
               bin_in = load_value;
            end
            bcd_in = '0;
         end
         CMD_SHIFT: begin
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         end
         CMD_POP: begin
            bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'b0000};
         end
         default: begin
            bin_in = bin_ff;
            bcd_in = bcd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

endmodule : itd_dabble

`default_nettype wire

// ===== hdl/itd_ctrl.sv =====
// ----------------------------------------------------------------------------
// itd_ctrl: sequencer for the integer-to-decimal converter
// Loads an item, runs the shift unit once per input bit, emits the sign, skips
// leading zero digits, then gives one digit character a cycle while slot_free.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_ctrl
   import itd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_sign,
   input  wire logic     slot_free,
   input  wire logic [3:0] top_digit,
   output logic          req_stall,
   output cmd_type       cmd,
   output emit_type      emit
);

   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(VALUE_WIDTH - 1);
   localparam logic [DIG_CNT_W-1:0] ALL_DIGS  = DIG_CNT_W'(NUM_DIGITS);
   localparam logic [DIG_CNT_W-1:0] ONE_DIG   = DIG_CNT_W'(1);

   state_type             state_ff;
   state_type             state_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff;
   logic [BIT_CNT_W-1:0]  bit_cnt_in;
   logic [DIG_CNT_W-1:0]  dig_cnt_ff;
   logic [DIG_CNT_W-1:0]  dig_cnt_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic                  skip_zero;
   logic                  last_dig;

   // A leading zero is dropped unless it is the only digit left.
   assign skip_zero = (top_digit == 4'd0) && (dig_cnt_ff > ONE_DIG);
   assign last_dig  = (dig_cnt_ff == ONE_DIG);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == '0) state_in = neg_ff ? ST_SIGN : ST_SKIP;
         end
         ST_SIGN: begin
            if (slot_free) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_zero) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free && last_dig) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: unit command, handshake and the character hand-off.
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd           = CMD_HOLD;
      emit.valid    = 1'b0;
      emit.char_out = ASCII_ZERO + {4'b0000, top_digit};
      emit.last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) cmd = CMD_LOAD;
         end
         ST_CONV: begin
            cmd = CMD_SHIFT;
         end
         ST_SIGN: begin
            emit.valid    = slot_free;
            emit.char_out = ASCII_MINUS;
         end
         ST_SKIP: begin
            if (skip_zero) cmd = CMD_POP;
         end
         ST_EMIT: begin
            emit.valid = slot_free;
            emit.last  = last_dig;
            if (slot_free) cmd = CMD_POP;
         end
         default: begin
            cmd = CMD_HOLD;
         end
      endcase
   end

   // Bit and digit counters and the sign flag.
   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      if (state_ff == ST_IDLE && req_valid) begin
         bit_cnt_in = LAST_BIT;
         dig_cnt_in = ALL_DIGS;
         neg_in     = req_sign;
      end else if (state_ff == ST_CONV) begin
         bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
      end else if (cmd == CMD_POP) begin
         dig_cnt_in = dig_cnt_ff - ONE_DIG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         neg_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         neg_ff     <= neg_in;
      end
   end

endmodule : itd_ctrl

`default_nettype wire

// ===== hdl/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed integer to decimal ASCII text
// Each item is one two's-complement integer; the block sends its decimal
// text one character per item, most significant digit first, with a leading
// '-' for negative values and last set on the final character.
//
//   Channel   Direction   Ports                              Per item
//   req       in          req_valid req_stall req_value      one integer
//   rsp       out         rsp_valid rsp_stall rsp_char_out   one character
//                         rsp_last
//
// The binary-to-BCD shift unit takes one input bit per cycle, and leading
// zero digits are dropped one per cycle.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled result holds the sequencer until the output register frees up;
// the next item is taken while the final character still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii
   import itd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic             [7:0]             rsp_char_out,
   output logic                               rsp_last
);

   // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

   cmd_type    cmd;
   emit_type   emit;
   logic [3:0] top_digit;
   logic       slot_free;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;

   // The output register can take a character when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   itd_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_sign  (req_value[VALUE_WIDTH-1]),
      .slot_free (slot_free),
      .top_digit (top_digit),
      .req_stall (req_stall),
      .cmd       (cmd),
      .emit      (emit)
   );

   itd_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (req_value),
      .top_digit  (top_digit)
   );

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_char_ff <= emit.char_out;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // An accepted item keeps the input side busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again right after an item");

   // While idle, no new character can appear once the register drains.
   assert property (@(posedge clock) disable iff (reset)
      !req_stall && !rsp_stall |=> !rsp_valid)
      else $error("character produced while the converter is idle");

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out == ASCII_MINUS) ||
                    ((rsp_char_out >= ASCII_ZERO) && (rsp_char_out <= ASCII_NINE)))
      else $error("character is neither a sign nor a digit");

   // The final character of a number is always a digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_char_out >= ASCII_ZERO) &&
                                (rsp_char_out <= ASCII_NINE))
      else $error("last character is not a digit");

endmodule : int_to_decimal_ascii

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the integer-to-decimal ASCII converter
// Sends signed 32-bit integers and checks each character that comes back,
// its code and its last flag, against the decimal text of the integer. A
// short table of directed values, some with their text typed in, comes
// first, then random values of every length. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
   import itd_pkg::*;
();

   localparam int WIDTH          = 32;
   localparam int RANDOM_ITEMS   = 130;
   localparam int QUIET_FROM     = 110;
   localparam int LONG_HOLD_AT   = 40;
   localparam int DRAIN_AT       = 80;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 60;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PRINT_LIMIT    = 40;
   localparam int DIRECTED_ITEMS = 20;

   // One character of decimal text as the block should send it.
   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } text_char_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WIDTH-1:0] req_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_char_out;
   logic             rsp_last;

   text_char_type    expected_chars[$];
   int               error_count   = 0;
   int               cycle_count   = 0;
   bit               quiet         = 1'b0;
   bit               hold_request  = 1'b0;

   logic [WIDTH-1:0] dir_value[DIRECTED_ITEMS];
   string            dir_text[DIRECTED_ITEMS];

   int_to_decimal_ascii #(
      .VALUE_WIDTH(WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_last    (rsp_last)
   );

   // Clock and the single reset at the start.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the block hangs or loses characters.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters pending",
                  cycle_count, expected_chars.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                  cycle_count, what, got, want);
   endtask

   // Decimal text of one two's-complement integer: sign first, then digits
   // most significant first, last set on the final digit.
   function automatic void predict_text(input logic [WIDTH-1:0] raw);
      logic [WIDTH-1:0] magnitude;
      logic [3:0]       digits[$];
      text_char_type    ch;
      magnitude = raw[WIDTH-1] ? (~raw + 1'b1) : raw;
      // Zero still gives one digit.
      do begin
         digits.push_front(4'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (raw[WIDTH-1]) begin
         ch.char_out = ASCII_MINUS;
         ch.last     = 1'b0;
         expected_chars.push_back(ch);
      end
      foreach (digits[i]) begin
         ch.char_out = ASCII_ZERO + 8'(digits[i]);
         ch.last     = (i == digits.size() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // Queues a text typed in by hand.
   function automatic void push_text(input string text);
      text_char_type ch;
      for (int i = 0; i < text.len(); i++) begin
         ch.char_out = text[i];
         ch.last     = (i == text.len() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // Offers one item and holds it until accepted. An empty text means the
   // expected characters come from the predictor.
   task automatic offer_value(input logic [WIDTH-1:0] value, input string text);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (text.len() == 0)
         predict_text(value);
      else
         push_text(text);
   endtask

   // Random sender gap after an accepted item.
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Random value: full-width noise, a random number of digits, or a
   // power of ten and its neighbors; either sign.
   function automatic logic [WIDTH-1:0] random_value();
      longint lo;
      longint hi;
      longint magnitude;
      int     ndigits;
      case ($urandom_range(0, 3)) inside
         0: return $urandom;
         [1:2]: begin
            ndigits = $urandom_range(1, 10);
            lo = 1;
            for (int i = 1; i < ndigits; i++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (ndigits == 1) lo = 0;
            if (hi > 64'd2147483648) hi = 64'd2147483648;
            magnitude = lo + longint'($urandom % (hi - lo + 1));
         end
         default: begin
            magnitude = 1;
            repeat ($urandom_range(0, 9)) magnitude = magnitude * 10;
            magnitude = magnitude + $urandom_range(0, 2) - 1;
         end
      endcase
      if ($urandom_range(0, 1) == 1)
         magnitude = -magnitude;
      else if (magnitude > 64'd2147483647)
         magnitude = 64'd2147483647;
      return magnitude[WIDTH-1:0];
   endfunction

   // Result checker: every accepted character against the oldest expectation.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", rsp_char_out, 0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_out !== want.char_out)
               report_mismatch("char_out", rsp_char_out, want.char_out);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, and no
   // stalls once the run turns quiet.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus: directed table, then random items, then drain and verdict.
   initial begin
      dir_value = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                    32'd2147483647, 32'h8000_0000, 32'h8000_0001, 32'd999999999,
                    32'd1000000000, -32'sd1000000000, 32'd12345, -32'sd909,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
      dir_text  = '{"0", "1", "-1", "9", "10", "-10", "99", "100",
                    "2147483647", "-2147483648", "-2147483647", "999999999",
                    "1000000000", "-1000000000", "12345", "-909",
                    "", "", "", ""};

      @(negedge reset);
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         offer_value(dir_value[i], dir_text[i]);
         sender_gap();
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // The receiver holds off while items keep coming, so the block fills.
         if (i == LONG_HOLD_AT) hold_request = 1'b1;
         // The sender waits here until every character has arrived.
         if (i == DRAIN_AT) begin
            req_valid <= 1'b0;
            wait (expected_chars.size() == 0);
            @(posedge clock);
         end
         if (i == QUIET_FROM) quiet = 1'b1;
         offer_value(random_value(), "");
         sender_gap();
      end
      req_valid <= 1'b0;

      wait (expected_chars.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
